// File: rtl/btc_pkg.sv
// btc_pkg: shared types, constants and the radix-2 divider step
// for the barometric compensation block. No dependencies.
`default_nettype none
package btc_pkg;
    localparam int unsigned RawW = 20;
    localparam int unsigned WordW = 32;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 64;

    localparam logic [CfgIdxW-1:0] CfgTempCalib = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgPressA = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgPressB = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgPressC = 2'd3;

    localparam logic [31:0] OffsetFine = 32'd64000;
    localparam logic [31:0] OffsetP1 = 32'd32768;
    localparam logic [31:0] PressFull = 32'd1048576;
    localparam logic [31:0] PressScale = 32'd3125;
    localparam logic [31:0] HalfRange = 32'h8000_0000;
    localparam logic [31:0] RoundTemp = 32'd128;

    // state of one divider lane
    typedef struct packed {
        logic        vld;
        logic [31:0] temp;
        logic        zero;
        logic        big;     // numerator was >= 2^31: double the quotient
        logic [31:0] dvs;
        logic [32:0] rem;
        logic [31:0] num;     // numerator bits shifted out as quotient fills in
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } btc_div_t;

    // one restoring step: bring down the top numerator bit, set a quotient bit
    function automatic btc_div_t div_step(btc_div_t s);
        btc_div_t    r;
        logic [32:0] trial;
        logic [33:0] diff;
        r = s;
        trial = {s.rem[31:0], s.num[31]};
        diff = {1'b0, trial} - {2'b00, s.dvs};
        if (!diff[33]) begin
            r.rem = diff[32:0];
            r.num = {s.num[30:0], 1'b1};
        end else begin
            r.rem = trial;
            r.num = {s.num[30:0], 1'b0};
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// File: rtl/baro_temp_compensation.sv
// baro_temp_compensation: compensated temperature and pressure from raw
// readings. Depends on btc_pkg and btc_divider.
// One transaction per cycle sustained while the output is not stalled by
// m_tready. The 32-stage divider pipeline sets most of the latency.
// Reset (synchronous, aresetn low) clears calibration and all valid bits.
`default_nettype none
module baro_temp_compensation (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0] m_tdata,        // temperature_centi[31:0], pressure_pa[63:32]
    output logic        m_tuser         // divisor_zero
);
    logic [47:0] tcal_reg;
    logic [63:0] pca_reg, pcb_reg;
    logic [15:0] pcc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tcal_reg <= '0; pca_reg <= '0; pcb_reg <= '0; pcc_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                btc_pkg::CfgTempCalib: tcal_reg <= cfg_wdata[47:0];
                btc_pkg::CfgPressA:    pca_reg <= cfg_wdata;
                btc_pkg::CfgPressB:    pcb_reg <= cfg_wdata;
                btc_pkg::CfgPressC:    pcc_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // sign-extended coefficients (t1 and p1 zero-extended)
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
    assign t1 = {16'd0, tcal_reg[15:0]};
    assign t2 = {{16{tcal_reg[31]}}, tcal_reg[31:16]};
    assign t3 = {{16{tcal_reg[47]}}, tcal_reg[47:32]};
    assign p1 = {16'd0, pca_reg[15:0]};
    assign p2 = {{16{pca_reg[31]}}, pca_reg[31:16]};
    assign p3 = {{16{pca_reg[47]}}, pca_reg[47:32]};
    assign p4 = {{16{pca_reg[63]}}, pca_reg[63:48]};
    assign p5 = {{16{pcb_reg[15]}}, pcb_reg[15:0]};
    assign p6 = {{16{pcb_reg[31]}}, pcb_reg[31:16]};

    // whole pipeline advances when the output slot is free or being taken
    logic adv;
    logic out_vld_reg;
    assign adv = !out_vld_reg || m_tready;
    assign s_tready = adv;

    function automatic logic [31:0] asr(logic [31:0] x, int n);
        return 32'($signed(x) >>> n);
    endfunction

    // S1: operand prep
    logic        v1_reg;
    logic [31:0] a1_reg, d1_reg, rp1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= s_tvalid;
        if (adv) begin
            a1_reg <= {15'd0, s_tdata[19:3]} - {t1[30:0], 1'b0};
            d1_reg <= {16'd0, s_tdata[19:4]} - t1;
            rp1_reg <= {12'd0, s_tdata[39:20]};
        end
    end
    // S2: first products
    logic        v2_reg;
    logic [31:0] a2_reg, dd2_reg, rp2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
        if (adv) begin
            a2_reg <= asr(32'(a1_reg * t2), 11);
            dd2_reg <= asr(32'(d1_reg * d1_reg), 12);
            rp2_reg <= rp1_reg;
        end
    end
    // S3: T3 product, fine temperature
    logic        v3_reg;
    logic [31:0] fine3_reg, rp3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
        if (adv) begin
            fine3_reg <= a2_reg + asr(32'(dd2_reg * t3), 14);
            rp3_reg <= rp2_reg;
        end
    end
    // S4: temperature, pressure offset base
    logic        v4_reg;
    logic [31:0] temp4_reg, a4_reg, q4_reg, rp4_reg;
    logic [31:0] a_fine;
    assign a_fine = asr(fine3_reg, 1) - btc_pkg::OffsetFine;
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (adv) v4_reg <= v3_reg;
        if (adv) begin
            temp4_reg <= asr(32'(fine3_reg * 32'd5) + btc_pkg::RoundTemp, 8);
            a4_reg <= a_fine;
            q4_reg <= asr(a_fine, 2);
            rp4_reg <= rp3_reg;
        end
    end
    // S5: q*q, a*p5, p2*a
    logic        v5_reg;
    logic [31:0] temp5_reg, qq5_reg, ap5_reg, p2a5_reg, rp5_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (adv) v5_reg <= v4_reg;
        if (adv) begin
            temp5_reg <= temp4_reg;
            qq5_reg <= 32'(q4_reg * q4_reg);
            ap5_reg <= 32'(a4_reg * p5);
            p2a5_reg <= asr(32'(p2 * a4_reg), 1);
            rp5_reg <= rp4_reg;
        end
    end
    // S6: p6 and p3 products
    logic        v6_reg;
    logic [31:0] temp6_reg, b6_reg, a6_reg, rp6_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v6_reg <= 1'b0;
        else if (adv) v6_reg <= v5_reg;
        if (adv) begin
            temp6_reg <= temp5_reg;
            b6_reg <= 32'(asr(qq5_reg, 11) * p6) + {ap5_reg[30:0], 1'b0};
            a6_reg <= asr(asr(32'(p3 * asr(qq5_reg, 13)), 3) + p2a5_reg, 18);
            rp6_reg <= rp5_reg;
        end
    end
    // S7: divisor and raw pressure term
    logic        v7_reg;
    logic [31:0] temp7_reg, div7_reg, pr7_reg;
    logic [31:0] b_fin;
    assign b_fin = asr(b6_reg, 2) + {p4[15:0], 16'd0};
    always_ff @(posedge aclk) begin
        if (!aresetn) v7_reg <= 1'b0;
        else if (adv) v7_reg <= v6_reg;
        if (adv) begin
            temp7_reg <= temp6_reg;
            div7_reg <= asr(32'((btc_pkg::OffsetP1 + a6_reg) * p1), 15);
            pr7_reg <= (btc_pkg::PressFull - rp6_reg) - asr(b_fin, 12);
        end
    end
    // S8: scale, build numerator
    logic        v8_reg;
    logic [31:0] temp8_reg, div8_reg, p8_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v8_reg <= 1'b0;
        else if (adv) v8_reg <= v7_reg;
        if (adv) begin
            temp8_reg <= temp7_reg;
            div8_reg <= div7_reg;
            p8_reg <= 32'(pr7_reg * btc_pkg::PressScale);
        end
    end

    btc_pkg::btc_div_t div_in, div_out;
    always_comb begin
        div_in.vld = v8_reg;
        div_in.temp = temp8_reg;
        div_in.zero = (div8_reg == '0);
        div_in.big = !(p8_reg < btc_pkg::HalfRange);
        div_in.dvs = div8_reg;
        div_in.rem = '0;
        div_in.num = div_in.big ? p8_reg : {p8_reg[30:0], 1'b0};
        div_in.p7 = pcb_reg[47:32];
        div_in.p8 = pcb_reg[63:48];
        div_in.p9 = pcc_reg;
    end

    btc_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .din(div_in), .dout(div_out)
    );

    // P1: quotient, squares
    logic        vq_reg;
    logic [31:0] tq_reg, pq_reg, sq_reg, pp8_reg;
    logic        zq_reg;
    logic [15:0] c7q_reg, c9q_reg;
    logic [31:0] quo;
    assign quo = div_out.zero ? 32'd0 : (div_out.big ? {div_out.num[30:0], 1'b0} : div_out.num);
    always_ff @(posedge aclk) begin
        if (!aresetn) vq_reg <= 1'b0;
        else if (adv) vq_reg <= div_out.vld;
        if (adv) begin
            tq_reg <= div_out.temp;
            zq_reg <= div_out.zero;
            pq_reg <= quo;
            sq_reg <= 32'({3'd0, quo[31:3]} * {3'd0, quo[31:3]}) >> 13;
            pp8_reg <= asr(32'({2'd0, quo[31:2]} * {{16{div_out.p8[15]}}, div_out.p8}), 13);
            c7q_reg <= div_out.p7;
            c9q_reg <= div_out.p9;
        end
    end
    // P2: p9 term
    logic        vr_reg;
    logic [31:0] tr_reg, pr_reg, sr_reg;
    logic        zr_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vr_reg <= 1'b0;
        else if (adv) vr_reg <= vq_reg;
        if (adv) begin
            tr_reg <= tq_reg;
            zr_reg <= zq_reg;
            pr_reg <= pq_reg;
            sr_reg <= asr(32'({{16{c9q_reg[15]}}, c9q_reg} * sq_reg), 12) + pp8_reg
                      + {{16{c7q_reg[15]}}, c7q_reg};
        end
    end
    // output register
    logic [31:0] ot_reg, op_reg;
    logic        oz_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) out_vld_reg <= 1'b0;
        else if (adv) out_vld_reg <= vr_reg;
        if (adv) begin
            ot_reg <= tr_reg;
            oz_reg <= zr_reg;
            op_reg <= zr_reg ? 32'd0 : pr_reg + asr(sr_reg, 4);
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata = {op_reg, ot_reg};
    assign m_tuser = oz_reg;
endmodule
`default_nettype wire

// File: rtl/btc_divider.sv
// btc_divider: 32-stage pipelined restoring divider, one quotient bit
// per stage, with a stall enable. Depends on btc_pkg.
`default_nettype none
module btc_divider (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire btc_pkg::btc_div_t din,
    output btc_pkg::btc_div_t      dout
);
    btc_pkg::btc_div_t stage_reg [32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 32; i++) stage_reg[i].vld <= 1'b0;
        end else if (en) begin
            stage_reg[0] <= btc_pkg::div_step(din);
            for (int i = 1; i < 32; i++) stage_reg[i] <= btc_pkg::div_step(stage_reg[i-1]);
        end
    end

    assign dout = stage_reg[31];
endmodule
`default_nettype wire
